>>> hw/rtl/pbtlv_pkg.sv
package pbtlv_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TAG   = 3'd1,
    PH_LEN   = 3'd2,
    PH_VALUE = 3'd3,
    PH_SKIP  = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    K_ORDER        = 4'd0,
    K_SEARCH_ATTR  = 4'd1,
    K_FILTER       = 4'd2,
    K_FORMAT       = 4'd3,
    K_MAX_COUNT    = 4'd4,
    K_START_OFFSET = 4'd5,
    K_SEARCH_START = 4'd6,
    K_SEARCH_BYTE  = 4'd7,
    K_DONE         = 4'd8,
    K_ERROR        = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    E_NONE    = 2'd0,
    E_SHORT   = 2'd1,
    E_OVERRUN = 2'd2,
    E_UNKNOWN = 2'd3
  } err_t;

  typedef enum logic [7:0] {
    TAG_ORDER        = 8'h01,
    TAG_SEARCH       = 8'h02,
    TAG_SEARCH_ATTR  = 8'h03,
    TAG_MAX_COUNT    = 8'h04,
    TAG_START_OFFSET = 8'h05,
    TAG_FILTER       = 8'h06,
    TAG_FORMAT       = 8'h07
  } tag_t;

  localparam logic [15:0] MinHeader = 16'd2;
  localparam logic [15:0] TailBytes = 16'd2;

  // one queue slot: a primary result, optionally followed by a done result
  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    err_t        err;
    logic        two;
  } q_entry_t;

  function automatic logic tag_known(input logic [7:0] tag);
    return (tag[7:3] == 5'd0) && (tag[2:0] != 3'd0);
  endfunction

  function automatic kind_t tag_kind(input logic [7:0] tag);
    kind_t k;
    unique case (tag)
      TAG_ORDER:        k = K_ORDER;
      TAG_SEARCH:       k = K_SEARCH_START;
      TAG_SEARCH_ATTR:  k = K_SEARCH_ATTR;
      TAG_MAX_COUNT:    k = K_MAX_COUNT;
      TAG_START_OFFSET: k = K_START_OFFSET;
      TAG_FILTER:       k = K_FILTER;
      TAG_FORMAT:       k = K_FORMAT;
      default:          k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] tag_len(input logic [7:0] tag);
    logic [7:0] l;
    unique case (tag)
      TAG_ORDER, TAG_SEARCH_ATTR, TAG_FORMAT: l = 8'd1;
      TAG_MAX_COUNT, TAG_START_OFFSET:        l = 8'd2;
      TAG_FILTER:                             l = 8'd8;
      default:                                l = 8'd0;
    endcase
    return l;
  endfunction

endpackage

>>> hw/rtl/pbtlv_if.sv
interface pbtlv_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  data_byte;
  logic [15:0] header_length;

  modport source (output valid, action, data_byte, header_length, input ready);
  modport sink   (input valid, action, data_byte, header_length, output ready);
endinterface

interface pbtlv_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [63:0] value;
  logic [1:0]  error_code;
  logic        last_of_run;

  modport source (output valid, kind, value, error_code, last_of_run, input ready);
  modport sink   (input valid, kind, value, error_code, last_of_run, output ready);
endinterface

>>> hw/rtl/pbtlv_front.sv
module pbtlv_front (
  input  logic                clk,
  input  logic                rst_n,
  pbtlv_in_if.sink            in_ch,
  input  logic                q_full,
  output logic                push,
  output pbtlv_pkg::q_entry_t push_entry
);
  import pbtlv_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [7:0]  vlen_r, vlen_nxt;
  logic [7:0]  seen_r, seen_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        discard_r, discard_nxt;

  logic        acc_in;
  logic [7:0]  b;
  logic [15:0] rem_dec;
  logic        known, search;
  logic        emit_p, emit_done;
  kind_t       p_kind;
  logic [63:0] p_value;
  err_t        p_err;

  assign in_ch.ready = !q_full;
  assign acc_in      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign rem_dec     = rem_r - 16'd1;
  assign known       = tag_known(tag_r);
  assign search      = (tag_r == TAG_SEARCH);

  always_comb begin
    phase_nxt   = phase_r;
    rem_nxt     = rem_r;
    tag_nxt     = tag_r;
    vlen_nxt    = vlen_r;
    seen_nxt    = seen_r;
    acc_nxt     = acc_r;
    discard_nxt = discard_r;
    emit_p      = 1'b0;
    emit_done   = 1'b0;
    p_kind      = K_ERROR;
    p_value     = 64'd0;
    p_err       = E_NONE;

    if (!in_ch.action) begin
      rem_nxt     = in_ch.header_length;
      tag_nxt     = 8'd0;
      vlen_nxt    = 8'd0;
      seen_nxt    = 8'd0;
      acc_nxt     = 64'd0;
      discard_nxt = 1'b0;
      if (in_ch.header_length < MinHeader) begin
        emit_p    = 1'b1;
        p_err     = E_SHORT;
        phase_nxt = (in_ch.header_length != 16'd0) ? PH_SKIP : PH_IDLE;
      end else if (in_ch.header_length > TailBytes) begin
        phase_nxt = PH_TAG;
      end else begin
        emit_done = 1'b1;
        phase_nxt = PH_SKIP;
      end
    end else begin
      unique case (phase_r)
        PH_SKIP: begin
          if (rem_r != 16'd0) rem_nxt = rem_dec;
          if (rem_r <= 16'd1) phase_nxt = PH_IDLE;
        end
        PH_TAG: begin
          tag_nxt   = b;
          rem_nxt   = rem_dec;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          rem_nxt = rem_dec;
          if ({8'd0, b} > rem_dec) begin
            emit_p    = 1'b1;
            p_err     = E_OVERRUN;
            phase_nxt = (rem_dec != 16'd0) ? PH_SKIP : PH_IDLE;
          end else if (!known) begin
            emit_p    = 1'b1;
            p_err     = E_UNKNOWN;
            phase_nxt = (rem_dec != 16'd0) ? PH_SKIP : PH_IDLE;
          end else begin
            vlen_nxt    = b;
            seen_nxt    = 8'd0;
            acc_nxt     = 64'd0;
            discard_nxt = !search && (b != tag_len(tag_r));
            if (search) begin
              emit_p  = 1'b1;
              p_kind  = K_SEARCH_START;
              p_value = {56'd0, b};
            end
            if (b == 8'd0) begin
              if (rem_dec > TailBytes) begin
                phase_nxt = PH_TAG;
              end else begin
                emit_done = 1'b1;
                phase_nxt = (rem_dec != 16'd0) ? PH_SKIP : PH_IDLE;
              end
            end else begin
              phase_nxt = PH_VALUE;
            end
          end
        end
        PH_VALUE: begin
          rem_nxt  = rem_dec;
          seen_nxt = seen_r + 8'd1;
          acc_nxt  = {acc_r[55:0], b};
          if (search) begin
            emit_p  = 1'b1;
            p_kind  = K_SEARCH_BYTE;
            p_value = {56'd0, b};
          end
          if (seen_nxt >= vlen_r) begin
            if (!search && !discard_r) begin
              emit_p  = 1'b1;
              p_kind  = tag_kind(tag_r);
              p_value = acc_nxt;
            end
            if (rem_dec > TailBytes) begin
              phase_nxt = PH_TAG;
            end else begin
              emit_done = 1'b1;
              phase_nxt = (rem_dec != 16'd0) ? PH_SKIP : PH_IDLE;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    // errors carry kind error and value zero
    if (p_err != E_NONE) p_kind = K_ERROR;
  end

  always_comb begin
    push             = acc_in && (emit_p || emit_done);
    push_entry.kind  = emit_p ? p_kind : K_DONE;
    push_entry.value = emit_p ? p_value : 64'd0;
    push_entry.err   = emit_p ? p_err : E_NONE;
    push_entry.two   = emit_p && emit_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      rem_r     <= 16'd0;
      tag_r     <= 8'd0;
      vlen_r    <= 8'd0;
      seen_r    <= 8'd0;
      acc_r     <= 64'd0;
      discard_r <= 1'b0;
    end else if (acc_in) begin
      phase_r   <= phase_nxt;
      rem_r     <= rem_nxt;
      tag_r     <= tag_nxt;
      vlen_r    <= vlen_nxt;
      seen_r    <= seen_nxt;
      acc_r     <= acc_nxt;
      discard_r <= discard_nxt;
    end
  end

endmodule

>>> hw/rtl/pbtlv_queue.sv
module pbtlv_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pbtlv_pkg::q_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output pbtlv_pkg::q_entry_t head
);
  import pbtlv_pkg::*;

  q_entry_t           mem_r [QDepth];
  logic [QAw-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QAw:0]       count_r, count_nxt;

  assign full  = (count_r == (QAw+1)'(QDepth));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

>>> hw/rtl/pbtlv_back.sv
module pbtlv_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                empty,
  input  pbtlv_pkg::q_entry_t head,
  output logic                pop,
  pbtlv_out_if.source         out_ch
);
  import pbtlv_pkg::*;

  logic second_r, second_nxt;
  logic take;

  assign out_ch.valid = !empty;
  assign take         = out_ch.valid && out_ch.ready;

  always_comb begin
    if (second_r) begin
      out_ch.kind        = K_DONE;
      out_ch.value       = 64'd0;
      out_ch.error_code  = E_NONE;
      out_ch.last_of_run = 1'b1;
    end else begin
      out_ch.kind        = head.kind;
      out_ch.value       = head.value;
      out_ch.error_code  = head.err;
      out_ch.last_of_run = !head.two;
    end
    pop        = take && (second_r || !head.two);
    second_nxt = second_r;
    if (take) second_nxt = !second_r && head.two;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) second_r <= 1'b0;
    else        second_r <= second_nxt;
  end

endmodule

>>> hw/rtl/phonebook_app_param_tlv_parser.sv
// Application-parameter TLV parser.
// in_ch: one request per cycle. action 0 starts a header of header_length
//   bytes, action 1 feeds one payload byte (ignored outside a header).
// out_ch: results in order - decoded fields, search start/bytes, done or
//   error; last_of_run flags the final result of each input request.
// A request gives zero, one or two results. The front parser takes one
//   request per cycle whenever its four-slot queue has room; each result is
//   held in a queue slot and offered on out_ch once it reaches the head.
// Throughput: one request per cycle in while the queue has room; one result
//   per cycle out while out_ch is ready, so two results share one head slot.
// A stalled out_ch only fills the queue; input keeps flowing until the
//   queue is full, then in_ch.ready drops until a slot frees.
// Reset (rst_n low, synchronous): parser idle, counters cleared, queue
//   emptied. No configuration registers.
module phonebook_app_param_tlv_parser (
  input  logic        clk,
  input  logic        rst_n,
  pbtlv_in_if.sink    in_ch,
  pbtlv_out_if.source out_ch
);
  import pbtlv_pkg::*;

  logic     q_full, q_empty, q_push, q_pop;
  q_entry_t q_in, q_head;

  // front: per-byte TLV state machine, classifies each request
  pbtlv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_in)
  );

  // decoupling queue; its slots double as the output register
  pbtlv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  // back: expands a slot into one or two results
  pbtlv_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (q_empty),
    .head   (q_head),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

>>> tb/tb_phonebook_app_param_tlv_parser.sv
module tb_phonebook_app_param_tlv_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import pbtlv_pkg::*;

  localparam int ClkHalf = 5;
  localparam int ItemTarget = 1400;   // rough size of the random part
  localparam int QuietLimit = 2000;   // cycles with no handshake at all
  localparam int DrainCycles = 20;    // trailing check for stray results
  localparam int PrintCap = 40;

  localparam logic ActBegin = 1'b0;
  localparam logic ActByte = 1'b1;
  localparam logic [7:0] TagNone = 8'h00;  // never a valid tag

  // one decoded result as it should appear on out_ch
  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    err_t        err;
    logic        last;
  } result_t;

  // one request; where fixed_exp is set, the expected outcome is typed in
  // (fixed_n results, 0 or 1) rather than taken from the parser model
  typedef struct packed {
    logic        act;
    logic [7:0]  data;
    logic [15:0] hlen;
    logic        fixed_exp;
    logic [1:0]  fixed_n;
    kind_t       kind;
    logic [63:0] value;
    err_t        err;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n;

  pbtlv_in_if  in_if ();
  pbtlv_out_if out_if ();

  phonebook_app_param_tlv_parser u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  always #(ClkHalf) clk = ~clk;

  // ---------------------------------------------------------------------
  // Directed requests. The early error, done and "nothing" outcomes are
  // typed in; the rest go through the parser model below.
  // ---------------------------------------------------------------------
  step_row_t directed_rows [26] = '{
    // stray byte straight after reset: parser idle, ignored
    '{ActByte,  8'hFF, 16'd0,     1'b1, 2'd0, K_DONE,  64'd0, E_NONE},
    // headers too short to hold a tag and a length
    '{ActBegin, 8'h00, 16'd0,     1'b1, 2'd1, K_ERROR, 64'd0, E_SHORT},
    '{ActBegin, 8'h00, 16'd1,     1'b1, 2'd1, K_ERROR, 64'd0, E_SHORT},
    // the one byte of that short header is swallowed
    '{ActByte,  8'h00, 16'd0,     1'b1, 2'd0, K_DONE,  64'd0, E_NONE},
    // two bytes only: leftover at once, done straight away
    '{ActBegin, 8'h00, 16'd2,     1'b1, 2'd1, K_DONE,  64'd0, E_NONE},
    // largest header, unknown tag, then abandoned by the next begin
    '{ActBegin, 8'h00, 16'hFFFF,  1'b1, 2'd0, K_DONE,  64'd0, E_NONE},
    '{ActByte,  TagNone, 16'd0,   1'b1, 2'd0, K_DONE,  64'd0, E_NONE},
    '{ActByte,  8'h05, 16'd0,     1'b1, 2'd1, K_ERROR, 64'd0, E_UNKNOWN},
    // declared length runs past the header end
    '{ActBegin, 8'h00, 16'd4,     1'b1, 2'd0, K_DONE,  64'd0, E_NONE},
    '{ActByte,  TAG_ORDER, 16'd0, 1'b1, 2'd0, K_DONE,  64'd0, E_NONE},
    '{ActByte,  8'hFF, 16'd0,     1'b1, 2'd1, K_ERROR, 64'd0, E_OVERRUN},
    // max count with the wrong length (dropped quietly), then a
    // one-byte search value ending the header
    '{ActBegin, 8'h00, 16'd6,     1'b0, 2'd0, K_DONE,  64'd0, E_NONE},
    '{ActByte,  TAG_MAX_COUNT, 16'd0, 1'b0, 2'd0, K_DONE, 64'd0, E_NONE},
    '{ActByte,  8'h01, 16'd0,     1'b0, 2'd0, K_DONE,  64'd0, E_NONE},
    '{ActByte,  8'h00, 16'd0,     1'b0, 2'd0, K_DONE,  64'd0, E_NONE},
    '{ActByte,  TAG_SEARCH, 16'd0, 1'b0, 2'd0, K_DONE, 64'd0, E_NONE},
    '{ActByte,  8'h01, 16'd0,     1'b0, 2'd0, K_DONE,  64'd0, E_NONE},
    '{ActByte,  8'h5A, 16'd0,     1'b0, 2'd0, K_DONE,  64'd0, E_NONE},
    // empty search value, a format field, then two leftover bytes
    '{ActBegin, 8'h00, 16'd7,     1'b0, 2'd0, K_DONE,  64'd0, E_NONE},
    '{ActByte,  TAG_SEARCH, 16'd0, 1'b0, 2'd0, K_DONE, 64'd0, E_NONE},
    '{ActByte,  8'h00, 16'd0,     1'b0, 2'd0, K_DONE,  64'd0, E_NONE},
    '{ActByte,  TAG_FORMAT, 16'd0, 1'b0, 2'd0, K_DONE, 64'd0, E_NONE},
    '{ActByte,  8'h01, 16'd0,     1'b0, 2'd0, K_DONE,  64'd0, E_NONE},
    '{ActByte,  8'h80, 16'd0,     1'b0, 2'd0, K_DONE,  64'd0, E_NONE},
    '{ActByte,  8'hAA, 16'd0,     1'b0, 2'd0, K_DONE,  64'd0, E_NONE},
    '{ActByte,  8'hBB, 16'd0,     1'b0, 2'd0, K_DONE,  64'd0, E_NONE}
  };

  // ---------------------------------------------------------------------
  // Parser model: header position and the field being collected.
  // ---------------------------------------------------------------------
  phase_t      hdr_phase = PH_IDLE;
  logic [15:0] hdr_left = 16'd0;
  logic [7:0]  fld_tag = 8'd0;
  logic [7:0]  fld_len = 8'd0;
  logic [7:0]  fld_seen = 8'd0;
  logic [63:0] fld_acc = 64'd0;
  logic        fld_ignored = 1'b0;

  result_t   step_results[$];   // results of the request just taken
  result_t   awaited[$];        // results still due on out_ch
  step_row_t shown_row;         // request currently on in_ch
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  bit        steady = 1'b0;     // no gaps or stalls while set

  // Kind and required length of a tag; 0 when the tag is unknown.
  function automatic bit field_spec(input logic [7:0] tag, output kind_t k,
                                    output logic [7:0] len);
    k = K_ERROR;
    len = 8'd0;
    case (tag)
      TAG_ORDER:        begin k = K_ORDER;        len = 8'd1; end
      TAG_SEARCH:       begin k = K_SEARCH_START; len = 8'd0; end
      TAG_SEARCH_ATTR:  begin k = K_SEARCH_ATTR;  len = 8'd1; end
      TAG_MAX_COUNT:    begin k = K_MAX_COUNT;    len = 8'd2; end
      TAG_START_OFFSET: begin k = K_START_OFFSET; len = 8'd2; end
      TAG_FILTER:       begin k = K_FILTER;       len = 8'd8; end
      TAG_FORMAT:       begin k = K_FORMAT;       len = 8'd1; end
      default:          return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function void add_result(input kind_t k, input logic [63:0] v, input err_t e);
    result_t r;
    r.kind = k;
    r.value = v;
    r.err = e;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  function void abort_header();
    hdr_phase = (hdr_left != 16'd0) ? PH_SKIP : PH_IDLE;
  endfunction

  function void fail_header(input err_t e);
    add_result(K_ERROR, 64'd0, e);
    abort_header();
  endfunction

  // end of a field: another triple fits, or report done, drop the tail
  function void end_field();
    if (hdr_left > TailBytes) begin
      hdr_phase = PH_TAG;
    end else begin
      add_result(K_DONE, 64'd0, E_NONE);
      abort_header();
    end
  endfunction

  function void parse_request(input logic act, input logic [7:0] b,
                              input logic [15:0] hl);
    kind_t      fk;
    logic [7:0] flen;
    bit         known;
    bit         search;
    known = field_spec(fld_tag, fk, flen);
    search = (fld_tag == TAG_SEARCH);
    step_results.delete();
    if (act == ActBegin) begin
      // a begin always wins, even mid-header
      hdr_phase = PH_IDLE;
      hdr_left = hl;
      fld_tag = 8'd0;
      fld_len = 8'd0;
      fld_seen = 8'd0;
      fld_acc = 64'd0;
      fld_ignored = 1'b0;
      if (hl < MinHeader) fail_header(E_SHORT);
      else end_field();
    end else begin
      case (hdr_phase)
        PH_SKIP: begin
          if (hdr_left != 16'd0) hdr_left = hdr_left - 16'd1;
          if (hdr_left == 16'd0) hdr_phase = PH_IDLE;
        end
        PH_TAG: begin
          fld_tag = b;
          hdr_left = hdr_left - 16'd1;
          hdr_phase = PH_LEN;
        end
        PH_LEN: begin
          hdr_left = hdr_left - 16'd1;
          // overrun is judged before the tag is looked at
          if ({8'd0, b} > hdr_left) begin
            fail_header(E_OVERRUN);
          end else if (!known) begin
            fail_header(E_UNKNOWN);
          end else begin
            fld_len = b;
            fld_seen = 8'd0;
            fld_acc = 64'd0;
            fld_ignored = !search && (b != flen);
            if (search) add_result(K_SEARCH_START, {56'd0, b}, E_NONE);
            if (b == 8'd0) end_field();
            else hdr_phase = PH_VALUE;
          end
        end
        PH_VALUE: begin
          hdr_left = hdr_left - 16'd1;
          fld_seen = fld_seen + 8'd1;
          fld_acc = {fld_acc[55:0], b};
          if (search) add_result(K_SEARCH_BYTE, {56'd0, b}, E_NONE);
          if (fld_seen >= fld_len) begin
            if (!search && !fld_ignored) add_result(fk, fld_acc, E_NONE);
            end_field();
          end
        end
        default: hdr_phase = PH_IDLE;
      endcase
    end
    if (step_results.size() != 0) step_results[step_results.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Pacing and driving.
  // ---------------------------------------------------------------------

  // mostly none or short, now and then a long one
  function automatic int hold_cycles();
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // an ordinary request, checked against the model; unused fields random
  function automatic step_row_t make_row(input logic act, input logic [7:0] b,
                                         input logic [15:0] hl);
    step_row_t row;
    row.act = act;
    row.data = (act == ActBegin) ? 8'($urandom_range(255)) : b;
    row.hlen = (act == ActBegin) ? hl : 16'($urandom_range(65535));
    row.fixed_exp = 1'b0;
    row.fixed_n = 2'd0;
    row.kind = K_DONE;
    row.value = 64'd0;
    row.err = E_NONE;
    return row;
  endfunction

  // presents one request at a falling edge and returns at the rising edge
  // where it is taken; valid stays high when the next follows at once
  task automatic send_request(input step_row_t row);
    int gap;
    gap = hold_cycles();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.action <= row.act;
    in_if.data_byte <= row.data;
    in_if.header_length <= row.hlen;
    shown_row <= row;
    do @(posedge clk); while (in_if.ready !== 1'b1);
  endtask

  // result side back-pressure
  initial begin : sink_pacing
    int stall;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = hold_cycles();
      @(negedge clk);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Checking. Both channels are sampled at the rising edge, before the
  // block's own updates land.
  // ---------------------------------------------------------------------
  task report(input string what, input logic [63:0] got, input logic [63:0] want_v);
    mismatch_count++;
    if (mismatch_count <= PrintCap)
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want_v);
  endtask

  always @(posedge clk) begin : scoreboard
    result_t want;
    if (rst_n === 1'b1) begin
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (awaited.size() == 0) begin
          report("result with no request outstanding", {60'd0, out_if.kind}, 64'd0);
        end else begin
          want = awaited.pop_front();
          if (out_if.kind !== want.kind)
            report("kind", {60'd0, out_if.kind}, {60'd0, want.kind});
          if (out_if.value !== want.value) report("value", out_if.value, want.value);
          if (out_if.error_code !== want.err)
            report("error_code", {62'd0, out_if.error_code}, {62'd0, want.err});
          if (out_if.last_of_run !== want.last)
            report("last_of_run", {63'd0, out_if.last_of_run}, {63'd0, want.last});
        end
      end
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        // the model always runs so its state tracks the block
        parse_request(in_if.action, in_if.data_byte, in_if.header_length);
        if (shown_row.fixed_exp) begin
          if (shown_row.fixed_n != 2'd0) begin
            want.kind = shown_row.kind;
            want.value = shown_row.value;
            want.err = shown_row.err;
            want.last = 1'b1;
            awaited.push_back(want);
          end
        end else begin
          foreach (step_results[i]) awaited.push_back(step_results[i]);
        end
      end
    end
  end

  // nothing moving on either channel for too long
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("** phonebook_app_param_tlv_parser: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus: directed table, then mostly well-formed headers with random
  // content, broken up by noise, bad lengths and cut-off headers.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int          sent;
    int          r;
    int          fields;
    int          fill;
    int          cut;
    int          i;
    logic [7:0]  tag;
    logic [7:0]  vlen;
    logic [7:0]  need;
    kind_t       k;
    logic [15:0] hl;
    logic [7:0]  plan[$];

    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.action = ActBegin;
    in_if.data_byte = 8'd0;
    in_if.header_length = 16'd0;
    shown_row = make_row(ActBegin, 8'd0, 16'd0);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[n]) send_request(directed_rows[n]);

    sent = 0;
    while (sent < ItemTarget) begin
      steady = (sent % 400) >= 300;
      r = $urandom_range(99);
      if (r < 4) begin
        // stray byte; ignored when idle, so not counted
        send_request(make_row(ActByte, 8'($urandom_range(255)), 16'd0));
      end else if (r < 10) begin
        // noise: any header length, a few random bytes
        send_request(make_row(ActBegin, 8'd0, 16'($urandom_range(65535))));
        cut = $urandom_range(0, 8);
        for (i = 0; i < cut; i++)
          send_request(make_row(ActByte, 8'($urandom_range(255)), 16'd0));
        sent += 1 + cut;
      end else begin
        plan.delete();
        fields = $urandom_range(1, 4);
        repeat (fields) begin
          r = $urandom_range(99);
          if (r < 85) tag = 8'($urandom_range(int'(TAG_ORDER), int'(TAG_FORMAT)));
          else tag = 8'($urandom_range(255));
          r = $urandom_range(99);
          if (tag == TAG_SEARCH) begin
            if (r < 85) vlen = 8'($urandom_range(0, 6));
            else if (r < 97) vlen = 8'($urandom_range(7, 40));
            else vlen = 8'($urandom_range(255));
          end else if (field_spec(tag, k, need)) begin
            vlen = (r < 80) ? need : 8'($urandom_range(0, 9));
          end else begin
            vlen = 8'($urandom_range(0, 5));
          end
          plan.push_back(tag);
          plan.push_back(vlen);
          fill = $urandom_range(9);
          repeat (vlen) begin
            if (fill == 0) plan.push_back(8'hFF);
            else if (fill == 1) plan.push_back(8'h00);
            else plan.push_back(8'($urandom_range(255)));
          end
        end
        // up to two trailing bytes that the parser should drop
        repeat ($urandom_range(0, 2)) plan.push_back(8'($urandom_range(255)));
        hl = 16'(plan.size());
        r = $urandom_range(99);
        if (r < 6) hl = 16'($urandom_range(1));
        else if (r < 13) hl = 16'($urandom_range(0, plan.size()));
        else if (r < 20) hl = hl + 16'($urandom_range(1, 3));
        // now and then the next begin cuts the header short
        cut = ($urandom_range(99) < 8) ? $urandom_range(0, plan.size()) : plan.size();
        send_request(make_row(ActBegin, 8'd0, hl));
        for (i = 0; i < cut; i++) send_request(make_row(ActByte, plan[i], 16'd0));
        sent += 1 + cut;
      end
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (awaited.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("** phonebook_app_param_tlv_parser: PASSED **");
    end else begin
      $display("** phonebook_app_param_tlv_parser: FAILED **");
    end
    $finish;
  end

endmodule
